@@ src/sliding_median_voltage_filter_assert.svh @@
// ----------------------------------------------------------------------------
// Sliding median voltage filter - assertion macros
// Shared property forms for the filter's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SLIDING_MEDIAN_VOLTAGE_FILTER_ASSERT_SVH
`define SLIDING_MEDIAN_VOLTAGE_FILTER_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define SMVF_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication under synchronous active-low reset
`define SMVF_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

@@ src/smvf_pkg.sv @@
// ----------------------------------------------------------------------------
// smvf_pkg
// Shared constants and types of the sliding median voltage filter.
// ----------------------------------------------------------------------------
package smvf_pkg;

  localparam int WINDOW_DEF      = 5;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int GAIN_W  = 24;
  localparam int MV_W    = 16;
  localparam int HELD_W  = 3;
  localparam int Q_SHIFT = 16;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd52813;
  localparam logic [MV_W-1:0]   MV_MAX     = 16'hFFFF;

  typedef struct packed {
    logic              done;
    logic [HELD_W-1:0] held;
  } sel_status_t;

endpackage

@@ src/smvf_select.sv @@
// ----------------------------------------------------------------------------
// smvf_select
// Ring store of the last samples and an extract-minimum sequencer that finds
// the sample of rank count/2 with one shared comparator, one entry per cycle.
// ----------------------------------------------------------------------------
module smvf_select #(
  parameter int WINDOW      = smvf_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = smvf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [SAMPLE_BITS-1:0]   sample,
  output logic [SAMPLE_BITS-1:0]   median,
  output smvf_pkg::sel_status_t    status
);

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);

  logic [SAMPLE_BITS-1:0] store_r [WINDOW];
  logic [IDX_W-1:0]       wp_r;
  logic [CNT_W-1:0]       fill_r;
  logic [WINDOW-1:0]      used_r;
  logic [CNT_W-1:0]       pass_r;
  logic [IDX_W-1:0]       scan_r;
  logic                   busy_r;
  logic                   done_r;
  logic                   best_ok_r;
  logic [SAMPLE_BITS-1:0] best_r;
  logic [IDX_W-1:0]       best_idx_r;
  logic [SAMPLE_BITS-1:0] med_r;

  logic [SAMPLE_BITS-1:0]            rd;
  logic                              take;
  logic                              last_scan;
  logic                              last_pass;
  logic [SAMPLE_BITS-1:0]            best_nxt;
  logic [IDX_W-1:0]                  best_idx_nxt;
  logic [CNT_W+smvf_pkg::HELD_W-1:0] fill_ext;

  assign rd           = store_r[scan_r];
  assign take         = !used_r[scan_r] && (!best_ok_r || (rd < best_r));
  assign last_scan    = (CNT_W'(scan_r) == (fill_r - CNT_W'(1)));
  assign last_pass    = (pass_r == (fill_r >> 1));
  assign best_nxt     = take ? rd : best_r;
  assign best_idx_nxt = take ? scan_r : best_idx_r;
  assign fill_ext     = {{smvf_pkg::HELD_W{1'b0}}, fill_r};

  always_ff @(posedge clk) begin
    if (start) begin
      store_r[wp_r] <= sample;
    end
    if (busy_r) begin
      best_r     <= best_nxt;
      best_idx_r <= best_idx_nxt;
      if (last_scan && last_pass) begin
        med_r <= best_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      fill_r    <= '0;
      used_r    <= '0;
      pass_r    <= '0;
      scan_r    <= '0;
      busy_r    <= 1'b0;
      done_r    <= 1'b0;
      best_ok_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        wp_r      <= (wp_r == IDX_W'(WINDOW - 1)) ? '0 : wp_r + IDX_W'(1);
        fill_r    <= (fill_r < CNT_W'(WINDOW)) ? fill_r + CNT_W'(1) : fill_r;
        used_r    <= '0;
        pass_r    <= '0;
        scan_r    <= '0;
        best_ok_r <= 1'b0;
        busy_r    <= 1'b1;
      end else if (busy_r) begin
        best_ok_r <= best_ok_r || take;
        if (last_scan) begin
          scan_r    <= '0;
          best_ok_r <= 1'b0;
          if (last_pass) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            used_r[best_idx_nxt] <= 1'b1;
            pass_r               <= pass_r + CNT_W'(1);
          end
        end else begin
          scan_r <= scan_r + IDX_W'(1);
        end
      end
    end
  end

  assign median      = med_r;
  assign status.done = done_r;
  assign status.held = fill_ext[smvf_pkg::HELD_W-1:0];

endmodule

@@ src/smvf_scale.sv @@
// ----------------------------------------------------------------------------
// smvf_scale
// Registered Q16 gain multiply of the median and saturation to millivolts.
// ----------------------------------------------------------------------------
module smvf_scale #(
  parameter int SAMPLE_BITS = smvf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic [SAMPLE_BITS-1:0]        median,
  input  logic [smvf_pkg::GAIN_W-1:0]   gain,
  output logic [smvf_pkg::MV_W-1:0]     mv
);

  localparam int PROD_W = SAMPLE_BITS + smvf_pkg::GAIN_W;
  localparam int HI_W   = PROD_W - smvf_pkg::Q_SHIFT;

  logic [PROD_W-1:0] prod_r;
  logic [HI_W-1:0]   hi;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= PROD_W'(median) * PROD_W'(gain);
    end
  end

  assign hi = prod_r[PROD_W-1:smvf_pkg::Q_SHIFT];
  assign mv = (hi > HI_W'(smvf_pkg::MV_MAX)) ? smvf_pkg::MV_MAX
                                              : hi[smvf_pkg::MV_W-1:0];

endmodule

@@ src/sliding_median_voltage_filter.sv @@
// ----------------------------------------------------------------------------
// sliding_median_voltage_filter
// Running median of the last WINDOW bus-voltage samples, scaled to mV.
//
// Input channel in_valid/in_ready carries one raw sample per transaction.
// Output channel out_valid/out_ready carries the median raw count, the
// median scaled by the Q16 gain in millivolts (saturated at 65535) and the
// number of samples that took part. One transaction in gives one out.
// cfg_wr_en/cfg_wr_data write the gain at once; write it only while idle.
// After a transaction is taken, in_ready stays low while one comparator
// scans the held samples, extracting the minimum n/2+1 times for n samples
// held, while the gain multiply is registered and until the result is loaded
// into the output register, so no new sample is taken before then.
// Reset empties the window, rewinds the write position and restores the
// gain to its default. If the receiver stalls, the result waits in the
// output register; one new input transaction is still taken and worked on,
// and its result is held back until the register frees.
// ----------------------------------------------------------------------------
module sliding_median_voltage_filter #(
  parameter int WINDOW      = smvf_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = smvf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SAMPLE_BITS-1:0]        in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [SAMPLE_BITS-1:0]        out_median_raw,
  output logic [smvf_pkg::MV_W-1:0]     out_voltage_mv,
  output logic [smvf_pkg::HELD_W-1:0]   out_samples_held,
  input  logic                          cfg_wr_en,
  input  logic [smvf_pkg::GAIN_W-1:0]   cfg_wr_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEL,
    ST_SCALE
  } state_t;

  state_t                        state_r;
  logic [smvf_pkg::GAIN_W-1:0]   gain_r;
  logic                          out_valid_r;
  logic [SAMPLE_BITS-1:0]        out_median_r;
  logic [smvf_pkg::MV_W-1:0]     out_mv_r;
  logic [smvf_pkg::HELD_W-1:0]   out_held_r;

  logic                          start;
  logic                          out_free;
  logic [SAMPLE_BITS-1:0]        median;
  smvf_pkg::sel_status_t         sel_status;
  logic [smvf_pkg::MV_W-1:0]     mv;

  assign in_ready = rst_n && (state_r == ST_IDLE);
  assign start    = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  smvf_select #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_select (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .sample (in_sample),
    .median (median),
    .status (sel_status)
  );

  smvf_scale #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale (
    .clk    (clk),
    .load   (sel_status.done),
    .median (median),
    .gain   (gain_r),
    .mv     (mv)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gain_r      <= smvf_pkg::GAIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        gain_r <= cfg_wr_data;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_SEL;
          end
        end
        ST_SEL: begin
          if (sel_status.done) begin
            state_r <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_SCALE) && out_free) begin
      out_median_r <= median;
      out_mv_r     <= mv;
      out_held_r   <= sel_status.held;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_median_raw   = out_median_r;
  assign out_voltage_mv   = out_mv_r;
  assign out_samples_held = out_held_r;

`include "sliding_median_voltage_filter_assert.svh"

  `SMVF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, start, !in_ready,
                    "input taken while previous transaction in progress")
  `SMVF_ASSERT_NOW(a_done_in_sel, clk, rst_n, sel_status.done, state_r == ST_SEL,
                   "median finished outside selection phase")
  `SMVF_ASSERT_NOW(a_held_nonzero, clk, rst_n, out_valid, out_samples_held != '0,
                   "result claims an empty window")
  `SMVF_ASSERT_NEXT(a_result_loaded, clk, rst_n, (state_r == ST_SCALE) && out_free,
                    out_valid && in_ready, "scaled result not presented")

endmodule
